// ===== sv/date_day_count_shift_core_defines.svh =====
// ============================================================================
// Assertion macros for the date day count shift core
// Concurrent checks that are compiled only for simulation; in synthesis the
// macros expand to nothing.
// ============================================================================
`ifndef DATE_DAY_COUNT_SHIFT_CORE_DEFINES_SVH
`define DATE_DAY_COUNT_SHIFT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DDCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddcs check failed");
`define DDCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddcs check failed");
`else
`define DDCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DDCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/ddcs_pkg.sv =====
// ============================================================================
// Date day count shift package
// Calendar constants, step and month tables, and the command and status
// types shared by the controller and the datapath.
// ============================================================================
package ddcs_pkg;

    localparam int MAX_YEAR = 9999;

    // Day count of 31 December MAX_YEAR, counting 1 January 1901 as day 1.
    localparam int LIMIT_INT = (MAX_YEAR - 1900) * 365
                             + (MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400)
                             - (1900 / 4 - 1900 / 100 + 1900 / 400);

    localparam logic [21:0] LIMIT       = 22'(LIMIT_INT);
    localparam logic [13:0] MAX_YEAR_V  = 14'(MAX_YEAR);
    localparam logic [13:0] FIRST_YEAR  = 14'd1901;
    // The division steps work relative to 1 January 1601, the start of a
    // 400-year cycle; 1901 lies 109572 days later.
    localparam logic [13:0] EPOCH_YEAR  = 14'd1601;
    localparam logic [21:0] EPOCH_DAYS  = 22'd109572;
    localparam logic [3:0]  STEP_LAST   = 4'd13;
    localparam logic [3:0]  MONTH_LAST  = 4'd11;

    typedef struct packed {
        logic [12:0] years;
        logic [21:0] days;
    } step_t;

    typedef struct packed {
        logic load;
        logic step;
        logic fwd;
        logic base;
        logic clamp;
        logic mprep;
        logic mstep;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic month_done;
    } status_t;

    // One restoring step of the mixed radix split into 400, 100, 4 and 1
    // year periods, largest multiple first.
    function automatic step_t step_entry(input logic [3:0] idx);
        step_t e;
        case (idx)
            4'd0:    e = '{13'd6400, 22'd2337552};
            4'd1:    e = '{13'd3200, 22'd1168776};
            4'd2:    e = '{13'd1600, 22'd584388};
            4'd3:    e = '{13'd800,  22'd292194};
            4'd4:    e = '{13'd400,  22'd146097};
            4'd5:    e = '{13'd200,  22'd73048};
            4'd6:    e = '{13'd100,  22'd36524};
            4'd7:    e = '{13'd64,   22'd23376};
            4'd8:    e = '{13'd32,   22'd11688};
            4'd9:    e = '{13'd16,   22'd5844};
            4'd10:   e = '{13'd8,    22'd2922};
            4'd11:   e = '{13'd4,    22'd1461};
            4'd12:   e = '{13'd2,    22'd730};
            4'd13:   e = '{13'd1,    22'd365};
            default: e = '{13'd0,    22'd0};
        endcase
        return e;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        case (idx)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the month in a common year.
    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/ddcs_dp.sv =====
// ============================================================================
// Date day count shift datapath
// Shared restoring step unit for year splitting in both directions, base
// count and clamp logic, month scan and the output register.
// ============================================================================
module ddcs_dp
(
    input  logic             clk,
    input  ddcs_pkg::cmd_t   cmd,
    input  logic [3:0]       step_idx,
    input  logic [4:0]       in_day,
    input  logic [3:0]       in_month,
    input  logic [13:0]      in_year,
    input  logic [22:0]      offset_days,
    output ddcs_pkg::status_t status,
    output logic [4:0]       out_day,
    output logic [3:0]       out_month,
    output logic [13:0]      out_year,
    output logic [21:0]      day_count,
    output logic             date_valid,
    output logic             saturated
);
    import ddcs_pkg::*;

    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [22:0] off_reg;
    logic        year_ok_reg;
    logic [21:0] rem_reg;
    logic [21:0] acc_reg;
    logic [13:0] taken_reg;
    logic [21:0] base_reg;
    logic        valid_reg;
    logic [21:0] n_reg;
    logic        sat_reg;
    logic [8:0]  r_reg;
    logic [3:0]  mon_reg;
    logic        leap_reg;
    logic [4:0]  out_day_reg;
    logic [3:0]  out_month_reg;
    logic [13:0] out_year_reg;
    logic [21:0] out_count_reg;
    logic        out_valid_flag_reg;
    logic        out_sat_reg;

    step_t       ent;
    logic [21:0] sub_val;
    logic [21:0] add_val;
    logic        take;
    logic        leap_now;
    logic [3:0]  month_idx;
    logic [4:0]  in_month_len;
    logic        date_ok;
    logic [21:0] base_next;
    logic [24:0] sum;
    logic [21:0] n_next;
    logic        sat_next;
    logic [4:0]  scan_len;
    logic        scan_go;
    logic        year_ok_in;

    always_comb
    begin
        ent     = step_entry(step_idx);
        sub_val = cmd.fwd ? {9'd0, ent.years} : ent.days;
        add_val = cmd.fwd ? ent.days : {9'd0, ent.years};
        take    = (rem_reg >= sub_val);

        // Quotient bits of the last steps: q1 in [1:0], q4 in [6:2], q100 in
        // [8:7]. The final year of a 4-year group is leap unless it closes a
        // century that is not the last of its 400-year cycle.
        leap_now = (taken_reg[1:0] == 2'd3)
                && ((taken_reg[6:2] != 5'd24) || (taken_reg[8:7] == 2'd3));

        month_idx    = month_reg - 4'd1;
        in_month_len = month_len(month_idx, leap_now);
        date_ok      = year_ok_reg && (month_reg >= 4'd1) && (month_reg <= 4'd12)
                    && (day_reg != 5'd0) && (day_reg <= in_month_len);
        base_next    = acc_reg - EPOCH_DAYS + 22'(days_before_month(month_idx))
                     + 22'(leap_now && (month_reg > 4'd2)) + 22'(day_reg);

        sum = $signed({3'b000, base_reg}) + $signed({{2{off_reg[22]}}, off_reg});
        if (sum[24])
        begin
            n_next   = '0;
            sat_next = 1'b0;
        end
        else if (sum > {3'b000, LIMIT})
        begin
            n_next   = LIMIT;
            sat_next = 1'b1;
        end
        else
        begin
            n_next   = sum[21:0];
            sat_next = 1'b0;
        end

        scan_len = month_len(mon_reg, leap_reg);
        scan_go  = (mon_reg < MONTH_LAST) && (r_reg > 9'(scan_len));
        status.month_done = !scan_go;

        year_ok_in = (in_year >= FIRST_YEAR) && (in_year <= MAX_YEAR_V);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            day_reg     <= in_day;
            month_reg   <= in_month;
            off_reg     <= offset_days;
            year_ok_reg <= year_ok_in;
            rem_reg     <= year_ok_in ? 22'(in_year - EPOCH_YEAR) : '0;
            acc_reg     <= '0;
            taken_reg   <= '0;
        end
        else if (cmd.step)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - sub_val;
                acc_reg <= acc_reg + add_val;
            end
            taken_reg <= {taken_reg[12:0], take};
        end
        else if (cmd.base)
        begin
            base_reg  <= date_ok ? base_next : '0;
            valid_reg <= date_ok;
        end
        else if (cmd.clamp)
        begin
            n_reg     <= n_next;
            sat_reg   <= sat_next;
            // Zero-based day number since the 1601 epoch for the reverse split.
            rem_reg   <= n_next + EPOCH_DAYS - 22'd1;
            acc_reg   <= '0;
            taken_reg <= '0;
        end
        else if (cmd.mprep)
        begin
            r_reg    <= rem_reg[8:0] + 9'd1;
            mon_reg  <= '0;
            leap_reg <= leap_now;
        end
        else if (cmd.mstep)
        begin
            if (scan_go)
            begin
                r_reg   <= r_reg - 9'(scan_len);
                mon_reg <= mon_reg + 4'd1;
            end
        end
        else if (cmd.out_load)
        begin
            if (n_reg == '0)
            begin
                out_day_reg   <= '0;
                out_month_reg <= '0;
                out_year_reg  <= '0;
            end
            else
            begin
                out_day_reg   <= r_reg[4:0];
                out_month_reg <= mon_reg + 4'd1;
                out_year_reg  <= acc_reg[13:0] + EPOCH_YEAR;
            end
            out_count_reg      <= n_reg;
            out_valid_flag_reg <= valid_reg;
            out_sat_reg        <= sat_reg;
        end
    end

    assign out_day    = out_day_reg;
    assign out_month  = out_month_reg;
    assign out_year   = out_year_reg;
    assign day_count  = out_count_reg;
    assign date_valid = out_valid_flag_reg;
    assign saturated  = out_sat_reg;

endmodule

// ===== sv/ddcs_ctrl.sv =====
// ============================================================================
// Date day count shift controller
// Sequences the forward split, base and clamp, reverse split, month scan
// and output handoff; owns both handshakes.
// ============================================================================
`include "date_day_count_shift_core_defines.svh"

module ddcs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ddcs_pkg::status_t status,
    output ddcs_pkg::cmd_t    cmd,
    output logic [3:0]        step_idx
);
    import ddcs_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_FDIV  = 8'b0000_0010,
        ST_BASE  = 8'b0000_0100,
        ST_CLAMP = 8'b0000_1000,
        ST_RDIV  = 8'b0001_0000,
        ST_MPREP = 8'b0010_0000,
        ST_MSCAN = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FDIV;
                end
            end
            ST_FDIV:
            begin
                cmd.step  = 1'b1;
                cmd.fwd   = 1'b1;
                step_next = step_reg + 4'd1;
                if (step_reg == STEP_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_RDIV;
            end
            ST_RDIV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 4'd1;
                if (step_reg == STEP_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_MPREP;
                end
            end
            ST_MPREP:
            begin
                cmd.mprep  = 1'b1;
                state_next = ST_MSCAN;
            end
            ST_MSCAN:
            begin
                cmd.mstep = 1'b1;
                if (status.month_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign step_idx = step_reg;

    `DDCS_ASSERT_NXT(a_accept_starts_split, clk, rst_n, s_tvalid && s_tready,
        state_reg == ST_FDIV && step_reg == 4'd0)
    `DDCS_ASSERT_NXT(a_split_ends_at_last_step, clk, rst_n,
        state_reg == ST_FDIV && step_reg == STEP_LAST, state_reg == ST_BASE)
    `DDCS_ASSERT_NXT(a_result_waits_for_room, clk, rst_n,
        state_reg == ST_OUT && out_valid_reg && !m_tready,
        state_reg == ST_OUT && out_valid_reg)

endmodule

// ===== sv/date_day_count_shift_core.sv =====
// ============================================================================
// Date day count shift core
// Shifts a Gregorian date by a signed number of days, with the day count
// based at 1 January 1901 and saturation at 31 December of the last year.
// ============================================================================
// Usage: the input stream carries one date and offset per beat; the output
// stream returns one beat per input beat with the shifted date, the day
// count and two flags. The sequencer works on one item at a time: s_tready
// is high while it is idle.
// An item runs a 14-step year split of the input year, a base count step,
// an offset add and clamp step, a 14-step split of the shifted count back
// into years, a setup step and a month scan. The result is then registered
// onto m_tdata. A new beat is taken only once the sequencer is back in idle;
// the two splits run one after the other through the shared step unit.
// The result sits in an output register, so the core goes back to idle and
// accepts the next item while a stalled result waits; it holds its second
// result until the first has been taken.
// Reset clears the sequencer and the output valid; no item is kept.
// ============================================================================
`include "date_day_count_shift_core_defines.svh"

module date_day_count_shift_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // in_day, in_month, in_year, offset_days, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // out_day, out_month, out_year, day_count, zero fill
    output logic [1:0]  m_tuser     // date_valid, saturated
);
    import ddcs_pkg::*;

    cmd_t        cmd;
    status_t     status;
    logic [3:0]  step_idx;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [21:0] day_count;
    logic        date_valid;
    logic        saturated;

    ddcs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .step_idx (step_idx)
    );

    ddcs_dp u_dp
    (
        .clk         (clk),
        .cmd         (cmd),
        .step_idx    (step_idx),
        .in_day      (s_tdata[4:0]),
        .in_month    (s_tdata[8:5]),
        .in_year     (s_tdata[22:9]),
        .offset_days (s_tdata[45:23]),
        .status      (status),
        .out_day     (out_day),
        .out_month   (out_month),
        .out_year    (out_year),
        .day_count   (day_count),
        .date_valid  (date_valid),
        .saturated   (saturated)
    );

    assign m_tdata = {3'b000, day_count, out_year, out_month, out_day};
    assign m_tuser = {saturated, date_valid};

    `DDCS_ASSERT_IMP(a_count_in_range, clk, rst_n, m_tvalid, day_count <= LIMIT)
    `DDCS_ASSERT_IMP(a_zero_count_zero_date, clk, rst_n, m_tvalid && day_count == '0,
        out_day == '0 && out_month == '0 && out_year == '0)
    `DDCS_ASSERT_IMP(a_saturated_at_limit, clk, rst_n, m_tvalid && saturated,
        day_count == LIMIT)

endmodule
